// ----- hw/rtl/clbs_pkg.sv -----
package clbs_pkg;

  // request codes on s_tuser
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_INSTR = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;
  localparam logic [1:0] REQ_POS   = 2'd3;

  // register word address bit (paddr[2])
  localparam logic CFG_BUS_MODE = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned INIT_BYTES  = 9;
  localparam logic [3:0]  INIT_LAST   = 4'(INIT_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_BYTE,
    KIND_POS
  } kind_e;

  // classified request, front to back
  typedef struct packed {
    kind_e      kind;
    logic       rs;
    logic [7:0] byte_val;
    logic [7:0] addr;
    logic       bad;
    logic       four;
  } desc_t;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_byte(input logic [3:0] idx, input logic four);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1, 4'd2: b = 8'h30;
      4'd3:             b = 8'h01;
      4'd4:             b = 8'h02;
      4'd5:             b = 8'h06;
      4'd6:             b = 8'h0C;
      4'd7:             b = four ? 8'h28 : 8'h38;
      default:          b = 8'h80;
    endcase
    return b;
  endfunction

  function automatic logic [14:0] init_wait(input logic [3:0] idx, input logic four);
    logic [14:0] w;
    unique case (idx)
      4'd0:    w = four ? 15'd20000 : 15'd15000;
      4'd1:    w = 15'd5000;
      4'd2:    w = four ? 15'd150 : 15'd100;
      default: w = 15'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/clbs_front.sv -----
module clbs_front import clbs_pkg::*; (
  input  logic [1:0] req_type_i,
  input  logic [7:0] byte_value_i,
  input  logic [2:0] row_i,
  input  logic [4:0] column_i,
  input  logic       bus_mode_i,
  output desc_t      desc_o
);

  logic       row_ok;
  logic [7:0] addr;

  assign row_ok = (row_i >= 3'd1) && (row_i <= 3'd4);
  // base + column - 1, wraps mod 256
  assign addr   = row_base(row_i[1:0] - 2'd1) + {3'b000, column_i} - 8'd1;

  always_comb begin
    desc_o          = '0;
    desc_o.byte_val = byte_value_i;
    desc_o.addr     = addr;
    desc_o.four     = bus_mode_i;
    unique case (req_type_i)
      REQ_INIT: begin
        desc_o.kind = KIND_INIT;
      end
      REQ_INSTR: begin
        desc_o.kind = KIND_BYTE;
      end
      REQ_DATA: begin
        desc_o.kind = KIND_BYTE;
        desc_o.rs   = 1'b1;
      end
      default: begin
        // bad row: data only, flagged
        desc_o.kind = row_ok ? KIND_POS : KIND_BYTE;
        desc_o.rs   = 1'b1;
        desc_o.bad  = !row_ok;
      end
    endcase
  end

endmodule

// ----- hw/rtl/clbs_queue.sv -----
module clbs_queue import clbs_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/clbs_back.sv -----
module clbs_back import clbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  desc_t       head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic [7:0]  bus_value_o,
  output logic [14:0] wait_o,
  output logic        status_o,
  output logic        last_o
);

  logic [3:0]  idx_q, idx_d;
  logic        nib_q, nib_d;
  logic        valid_q, valid_d;
  logic        rs_q, status_q, last_q;
  logic [7:0]  bus_q;
  logic [14:0] wait_q;

  logic        issue, last_byte, strobe_last, rs;
  logic [7:0]  b, bus;
  logic [14:0] wt;

  assign issue = head_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    b         = head_i.byte_val;
    rs        = head_i.rs;
    wt        = '0;
    last_byte = 1'b1;
    unique case (head_i.kind)
      KIND_INIT: begin
        b         = init_byte(idx_q, head_i.four);
        rs        = 1'b0;
        wt        = nib_q ? 15'd0 : init_wait(idx_q, head_i.four);
        last_byte = (idx_q == INIT_LAST);
      end
      KIND_POS: begin
        if (idx_q == 4'd0) begin
          b         = head_i.addr;
          rs        = 1'b0;
          last_byte = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (head_i.four) begin
      bus = nib_q ? {4'h0, b[3:0]} : {4'h0, b[7:4]};
    end else begin
      bus = b;
    end
    strobe_last = last_byte && (!head_i.four || nib_q);
  end

  assign pop_o = issue && strobe_last;

  always_comb begin
    idx_d = idx_q;
    nib_d = nib_q;
    if (issue) begin
      if (strobe_last) begin
        idx_d = '0;
        nib_d = 1'b0;
      end else if (head_i.four && !nib_q) begin
        nib_d = 1'b1;
      end else begin
        nib_d = 1'b0;
        idx_d = idx_q + 4'd1;
      end
    end
    valid_d = issue ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      nib_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      nib_q   <= nib_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rs_q     <= rs;
      bus_q    <= bus;
      wait_q   <= wt;
      status_q <= strobe_last && head_i.bad;
      last_q   <= strobe_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign reg_select_o = rs_q;
  assign bus_value_o  = bus_q;
  assign wait_o       = wait_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

// ----- hw/rtl/char_lcd_bus_sequencer.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: byte_value, row, column
// m_*       out  m_tvalid/m_tready  tuser: reg_select, status; tdata: bus_value,
//                                   wait_before_us; tlast: last strobe of run
// apb       in   psel/penable       bus_mode at byte address 0
//
// One strobe leaves per cycle while m_tready is high; a request takes as many
// strobes as its kind needs: 1 or 2 (byte), 2 or 4 (positioned; 1 or 2 with
// an invalid row), 9 or 18 (init). The back-end sequencer sets that figure.
// Requests are taken every cycle while the descriptor queue has room, so
// the front keeps accepting while the back end drains a long init run.
// Reset (rst_ni low, asynchronous) empties the queue, drops m_tvalid and sets
// bus_mode to eight lines. A stall on m_tready holds the output register.
module char_lcd_bus_sequencer import clbs_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], row[10:8], column[15:11]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // strobe stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bus_value[7:0], wait_before_us[22:8], zero[23]
  output logic [1:0]  m_tuser,   // reg_select[0], status[1]
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic  bus_mode_q, bus_mode_d;
  logic  cfg_wr;
  desc_t front_desc, head;
  logic  q_full, q_valid, pop, push;
  logic  rs, status;
  logic  [7:0]  bus_value;
  logic  [14:0] wait_us;

  // register file: one bit, word-decoded on paddr[2]
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == CFG_BUS_MODE);
  assign bus_mode_d = cfg_wr ? pwdata[0] : bus_mode_q;
  assign prdata     = (paddr[2] == CFG_BUS_MODE) ? {31'd0, bus_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q <= 1'b0;
    end else begin
      bus_mode_q <= bus_mode_d;
    end
  end

  // front: classify the request and compute the cursor address
  clbs_front u_front (
    .req_type_i   (s_tuser),
    .byte_value_i (s_tdata[7:0]),
    .row_i        (s_tdata[10:8]),
    .column_i     (s_tdata[15:11]),
    .bus_mode_i   (bus_mode_q),
    .desc_o       (front_desc)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  clbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // back: walk bytes and nibbles of the head descriptor, one transfer a cycle while m_tready is high
  clbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .reg_select_o (rs),
    .bus_value_o  (bus_value),
    .wait_o       (wait_us),
    .status_o     (status),
    .last_o       (m_tlast)
  );

  assign m_tdata = {1'b0, wait_us, bus_value};
  assign m_tuser = {status, rs};

endmodule

// ----- hw/rtl/clbs_checker.sv -----
module clbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // stalled transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled strobe changed");

  // error flag only on the closing data strobe
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
    else $error("status outside last data strobe");

  // delays belong to init instruction strobes only
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tdata[22:8] != 15'd0) |-> !m_tuser[0] && !m_tlast
      && (m_tdata[7:0] == 8'h30 || m_tdata[7:0] == 8'h03))
    else $error("wait on unexpected strobe");

  // nothing offered straight out of reset
  a_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
